/* src/cst_pkg.sv */
// Shared types, token codes and character classes for the C-subset token scanner.
package cst_pkg;

    localparam int RES_MAX = 3;
    localparam int KIND_W  = 6;
    localparam int LINE_W  = 16;
    localparam int LEN_W   = 8;
    localparam int KW_NUM  = 12;

    typedef enum logic [3:0] {
        M_START, M_IDENT, M_NUM, M_STR, M_BANG, M_AMP, M_PIPE, M_LT, M_GT,
        M_EQ, M_SLASH, M_LCOM, M_BCOM, M_BSTAR, M_ERR
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [LINE_W-1:0] line_number;
        logic [LEN_W-1:0]  token_length;
        logic              run_last;
    } t_result;

    typedef t_result [RES_MAX-1:0] t_result_set;

    // Token kinds
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd0;
    localparam logic [KIND_W-1:0] K_INT    = 6'd1;
    localparam logic [KIND_W-1:0] K_STR    = 6'd2;
    localparam logic [KIND_W-1:0] K_MAIN   = 6'd3;
    localparam logic [KIND_W-1:0] K_CONST  = 6'd4;
    localparam logic [KIND_W-1:0] K_INTKW  = 6'd5;
    localparam logic [KIND_W-1:0] K_BREAK  = 6'd6;
    localparam logic [KIND_W-1:0] K_CONT   = 6'd7;
    localparam logic [KIND_W-1:0] K_IF     = 6'd8;
    localparam logic [KIND_W-1:0] K_ELSE   = 6'd9;
    localparam logic [KIND_W-1:0] K_NOT    = 6'd10;
    localparam logic [KIND_W-1:0] K_AND    = 6'd11;
    localparam logic [KIND_W-1:0] K_OR     = 6'd12;
    localparam logic [KIND_W-1:0] K_WHILE  = 6'd13;
    localparam logic [KIND_W-1:0] K_GETINT = 6'd14;
    localparam logic [KIND_W-1:0] K_PRINTF = 6'd15;
    localparam logic [KIND_W-1:0] K_RETURN = 6'd16;
    localparam logic [KIND_W-1:0] K_PLUS   = 6'd17;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd18;
    localparam logic [KIND_W-1:0] K_VOID   = 6'd19;
    localparam logic [KIND_W-1:0] K_MULT   = 6'd20;
    localparam logic [KIND_W-1:0] K_DIV    = 6'd21;
    localparam logic [KIND_W-1:0] K_MOD    = 6'd22;
    localparam logic [KIND_W-1:0] K_LSS    = 6'd23;
    localparam logic [KIND_W-1:0] K_LEQ    = 6'd24;
    localparam logic [KIND_W-1:0] K_GRE    = 6'd25;
    localparam logic [KIND_W-1:0] K_GEQ    = 6'd26;
    localparam logic [KIND_W-1:0] K_EQL    = 6'd27;
    localparam logic [KIND_W-1:0] K_NEQ    = 6'd28;
    localparam logic [KIND_W-1:0] K_ASSIGN = 6'd29;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd30;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd31;
    localparam logic [KIND_W-1:0] K_LPAR   = 6'd32;
    localparam logic [KIND_W-1:0] K_RPAR   = 6'd33;
    localparam logic [KIND_W-1:0] K_LBRK   = 6'd34;
    localparam logic [KIND_W-1:0] K_RBRK   = 6'd35;
    localparam logic [KIND_W-1:0] K_LBRC   = 6'd36;
    localparam logic [KIND_W-1:0] K_RBRC   = 6'd37;
    localparam logic [KIND_W-1:0] K_END    = 6'd38;
    localparam logic [KIND_W-1:0] K_ERR    = 6'd39;

    // Characters with a role of their own
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_BANG  = 8'd33;
    localparam logic [7:0] CH_AMP   = 8'd38;
    localparam logic [7:0] CH_PIPE  = 8'd124;
    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_STAR  = 8'd42;

    // Keywords, right-aligned in a 64-bit window of up to eight bytes
    localparam logic [63:0] KW_TEXT [KW_NUM] = '{
        64'("const"), 64'("main"), 64'("int"), 64'("break"), 64'("continue"),
        64'("if"), 64'("else"), 64'("while"), 64'("getint"), 64'("printf"),
        64'("return"), 64'("void")
    };
    localparam logic [KIND_W-1:0] KW_KIND [KW_NUM] = '{
        K_CONST, K_MAIN, K_INTKW, K_BREAK, K_CONT, K_IF,
        K_ELSE, K_WHILE, K_GETINT, K_PRINTF, K_RETURN, K_VOID
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'd97:8'd122], [8'd65:8'd90], 8'd95});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'd48:8'd57]});
    endfunction

    // Compare the window against all keywords in parallel.
    function automatic logic [KIND_W-1:0] kw_lookup(input logic [63:0] win,
                                                    input logic too_long);
        logic [KIND_W-1:0] kind;
        kind = K_IDENT;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            if (win == KW_TEXT[k]) begin
                kind = KW_KIND[k];
            end
        end
        if (too_long) begin
            kind = K_IDENT;
        end
        return kind;
    endfunction

endpackage

/* src/cst_if.sv */
// Handshake channels for source bytes and token results.
interface cst_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cst_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] line_number;
    logic [7:0]  token_length;
    logic        run_last;

    modport source (output valid, output token_kind, output line_number,
                    output token_length, output run_last, input ready);
    modport sink   (input valid, input token_kind, input line_number,
                    input token_length, input run_last, output ready);
endinterface

/* src/c_subset_token_scanner_top.sv */
// Top level of the C-subset token scanner: byte intake and result word buffer.
// Latency: a word caused by a byte is offered on o_token the cycle after the byte is taken.
// Throughput: one byte in and one word out per cycle while o_token is ready and each byte yields
//   at most one word; a byte yielding two or three words holds intake until its last word goes.
// Reset (synchronous, active low): start state, line 1, length 0, result buffer empty.
module c_subset_token_scanner_top #(
    parameter int LINE_BITS   = 16,
    parameter int LENGTH_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cst_char_if.sink           i_char,
    cst_token_if.source        o_token
);
    import cst_pkg::*;

    t_result_set r_slot, n_slot;
    logic [1:0]  r_cnt, n_cnt;
    t_result_set scan_res;
    logic [1:0]  scan_cnt;
    logic        take;
    logic        pop;

    // Pop the head word when the sink takes it
    assign pop = (r_cnt != 2'd0) && o_token.ready;

    // Take a byte when the buffer is empty or its last word leaves this cycle
    assign i_char.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_token.ready);
    assign take         = i_char.valid && i_char.ready;

    cst_scan #(
        .LINE_BITS   (LINE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_code (i_char.char_code),
        .i_last_char (i_char.last_char),
        .o_res       (scan_res),
        .o_res_cnt   (scan_cnt)
    );

    // Load the words of a new byte, or advance the buffer by one word
    always_comb begin
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (take) begin
            n_slot = scan_res;
            n_cnt  = scan_cnt;
        end else if (pop) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_cnt     = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_token.valid        = (r_cnt != 2'd0);
    assign o_token.token_kind   = r_slot[0].token_kind;
    assign o_token.line_number  = r_slot[0].line_number;
    assign o_token.token_length = r_slot[0].token_length;
    assign o_token.run_last     = r_slot[0].run_last;

endmodule

/* src/cst_scan.sv */
// Scanner state registers and the per-byte token logic.
module cst_scan #(
    parameter int LINE_BITS   = 16,
    parameter int LENGTH_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_char_code,
    input  logic                 i_last_char,
    output cst_pkg::t_result_set o_res,
    output logic [1:0]           o_res_cnt
);
    import cst_pkg::*;

    localparam int CAND = 4;

    t_mode                  r_mode, n_mode;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [63:0]            r_win, n_win;

    logic [LENGTH_BITS-1:0] len_inc;
    logic [63:0]            win_shift;
    logic                   used;
    logic [LINE_BITS-1:0]   line_mid;
    logic [CAND-1:0]        e_v;
    logic [KIND_W-1:0]      e_kind [CAND];
    logic [LENGTH_BITS-1:0] e_len [CAND];
    logic [LINE_W-1:0]      line_old_o, line_mid_o;
    t_result                cand [CAND];
    logic [1:0]             cnt;

    assign len_inc   = (r_len != '1) ? r_len + LENGTH_BITS'(1) : r_len;
    assign win_shift = (r_len < LENGTH_BITS'(8)) ? {r_win[55:0], i_char_code} : r_win;

    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        n_len  = r_len;
        n_win  = r_win;
        used   = 1'b0;
        e_v    = '0;
        for (int i = 0; i < CAND; i++) begin
            e_kind[i] = K_ERR;
            e_len[i]  = '0;
        end

        // Continue the pending token
        case (r_mode)
            M_IDENT: begin
                if (is_alpha(i_char_code) || is_digit(i_char_code)) begin
                    n_len = len_inc; n_win = win_shift; used = 1'b1;
                end else begin
                    e_v[0] = 1'b1;
                    e_kind[0] = kw_lookup(r_win, r_len > LENGTH_BITS'(8));
                    e_len[0] = r_len;
                    n_mode = M_START;
                end
            end
            M_NUM: begin
                if (is_digit(i_char_code)) begin
                    n_len = len_inc; n_win = win_shift; used = 1'b1;
                end else begin
                    e_v[0] = 1'b1; e_kind[0] = K_INT; e_len[0] = r_len;
                    n_mode = M_START;
                end
            end
            M_STR: begin
                used = 1'b1;
                if (i_char_code == CH_QUOTE) begin
                    n_len = len_inc; n_win = win_shift;
                    e_v[0] = 1'b1; e_kind[0] = K_STR; e_len[0] = len_inc;
                    n_mode = M_START;
                end else if (i_char_code inside {[8'd32:8'd126]}) begin
                    n_len = len_inc; n_win = win_shift;
                end else begin
                    e_v[0] = 1'b1; e_kind[0] = K_ERR;
                    n_mode = M_ERR;
                end
            end
            M_BANG, M_LT, M_GT, M_EQ: begin
                n_mode = M_START;
                e_v[0] = 1'b1;
                if (i_char_code == CH_EQ) begin
                    used = 1'b1;
                    e_len[0] = LENGTH_BITS'(2);
                    case (r_mode)
                        M_BANG:  e_kind[0] = K_NEQ;
                        M_LT:    e_kind[0] = K_LEQ;
                        M_GT:    e_kind[0] = K_GEQ;
                        default: e_kind[0] = K_EQL;
                    endcase
                end else begin
                    e_len[0] = LENGTH_BITS'(1);
                    case (r_mode)
                        M_BANG:  e_kind[0] = K_NOT;
                        M_LT:    e_kind[0] = K_LSS;
                        M_GT:    e_kind[0] = K_GRE;
                        default: e_kind[0] = K_ASSIGN;
                    endcase
                end
            end
            M_AMP, M_PIPE: begin
                used = 1'b1;
                e_v[0] = 1'b1;
                if ((r_mode == M_AMP && i_char_code == CH_AMP) ||
                    (r_mode == M_PIPE && i_char_code == CH_PIPE)) begin
                    e_kind[0] = (r_mode == M_AMP) ? K_AND : K_OR;
                    e_len[0]  = LENGTH_BITS'(2);
                    n_mode    = M_START;
                end else begin
                    e_kind[0] = K_ERR;
                    n_mode    = M_ERR;
                end
            end
            M_SLASH: begin
                if (i_char_code == CH_SLASH) begin
                    n_mode = M_LCOM; used = 1'b1;
                end else if (i_char_code == CH_STAR) begin
                    n_mode = M_BCOM; used = 1'b1;
                end else begin
                    e_v[0] = 1'b1; e_kind[0] = K_DIV; e_len[0] = LENGTH_BITS'(1);
                    n_mode = M_START;
                end
            end
            M_LCOM: begin
                used = 1'b1;
                if (i_char_code == CH_NL) begin
                    if (n_line != '1) n_line = n_line + LINE_BITS'(1);
                    n_mode = M_START;
                end
            end
            M_BCOM, M_BSTAR: begin
                used = 1'b1;
                if (i_char_code == CH_NL) begin
                    if (n_line != '1) n_line = n_line + LINE_BITS'(1);
                    n_mode = M_BCOM;
                end else if (i_char_code == CH_STAR) begin
                    n_mode = M_BSTAR;
                end else if (i_char_code == CH_SLASH && r_mode == M_BSTAR) begin
                    n_mode = M_START;
                end else begin
                    n_mode = M_BCOM;
                end
            end
            M_ERR: begin
                used = 1'b1;
            end
            default: begin
                n_mode = M_START;
            end
        endcase

        // Start a new token with the byte
        if (!used) begin
            n_mode = M_START;
            n_len  = LENGTH_BITS'(1);
            e_len[1] = LENGTH_BITS'(1);
            case (i_char_code)
                CH_NL: begin
                    if (n_line != '1) n_line = n_line + LINE_BITS'(1);
                    n_len = '0;
                end
                8'd32, 8'd9, 8'd11, 8'd12, 8'd13: n_len = '0;
                CH_QUOTE: n_mode = M_STR;
                CH_BANG:  n_mode = M_BANG;
                CH_AMP:   n_mode = M_AMP;
                CH_PIPE:  n_mode = M_PIPE;
                CH_LT:    n_mode = M_LT;
                CH_GT:    n_mode = M_GT;
                CH_EQ:    n_mode = M_EQ;
                CH_SLASH: n_mode = M_SLASH;
                8'd43:  begin e_v[1] = 1'b1; e_kind[1] = K_PLUS;  end
                8'd45:  begin e_v[1] = 1'b1; e_kind[1] = K_MINUS; end
                CH_STAR: begin e_v[1] = 1'b1; e_kind[1] = K_MULT; end
                8'd37:  begin e_v[1] = 1'b1; e_kind[1] = K_MOD;   end
                8'd59:  begin e_v[1] = 1'b1; e_kind[1] = K_SEMI;  end
                8'd44:  begin e_v[1] = 1'b1; e_kind[1] = K_COMMA; end
                8'd40:  begin e_v[1] = 1'b1; e_kind[1] = K_LPAR;  end
                8'd41:  begin e_v[1] = 1'b1; e_kind[1] = K_RPAR;  end
                8'd91:  begin e_v[1] = 1'b1; e_kind[1] = K_LBRK;  end
                8'd93:  begin e_v[1] = 1'b1; e_kind[1] = K_RBRK;  end
                8'd123: begin e_v[1] = 1'b1; e_kind[1] = K_LBRC;  end
                8'd125: begin e_v[1] = 1'b1; e_kind[1] = K_RBRC;  end
                default: begin
                    if (is_alpha(i_char_code)) begin
                        n_mode = M_IDENT;
                        n_win  = {56'd0, i_char_code};
                    end else if (is_digit(i_char_code)) begin
                        n_mode = M_NUM;
                    end else begin
                        e_v[1] = 1'b1; e_kind[1] = K_ERR; e_len[1] = '0;
                        n_mode = M_ERR;
                    end
                end
            endcase
        end

        line_mid = n_line;

        // Flush the pending token at the end of the text, then restart
        if (i_last_char) begin
            case (n_mode)
                M_IDENT: begin
                    e_v[2] = 1'b1;
                    e_kind[2] = kw_lookup(n_win, n_len > LENGTH_BITS'(8));
                    e_len[2] = n_len;
                end
                M_NUM:   begin e_v[2] = 1'b1; e_kind[2] = K_INT;    e_len[2] = n_len; end
                M_BANG:  begin e_v[2] = 1'b1; e_kind[2] = K_NOT;    e_len[2] = LENGTH_BITS'(1); end
                M_LT:    begin e_v[2] = 1'b1; e_kind[2] = K_LSS;    e_len[2] = LENGTH_BITS'(1); end
                M_GT:    begin e_v[2] = 1'b1; e_kind[2] = K_GRE;    e_len[2] = LENGTH_BITS'(1); end
                M_EQ:    begin e_v[2] = 1'b1; e_kind[2] = K_ASSIGN; e_len[2] = LENGTH_BITS'(1); end
                M_SLASH: begin e_v[2] = 1'b1; e_kind[2] = K_DIV;    e_len[2] = LENGTH_BITS'(1); end
                M_STR, M_AMP, M_PIPE, M_BCOM, M_BSTAR: begin
                    e_v[2] = 1'b1; e_kind[2] = K_ERR;
                end
                default: ;
            endcase
            e_v[3]    = 1'b1;
            e_kind[3] = K_END;
            n_mode = M_START;
            n_line = LINE_BITS'(1);
            n_len  = '0;
            n_win  = '0;
        end
    end

    // Clamp line numbers to the 16-bit result field
    assign line_old_o = (32'(r_line) > 32'(16'hFFFF)) ? '1 : 16'(32'(r_line));
    assign line_mid_o = (32'(line_mid) > 32'(16'hFFFF)) ? '1 : 16'(32'(line_mid));

    always_comb begin
        for (int i = 0; i < CAND; i++) begin
            cand[i].token_kind   = e_kind[i];
            cand[i].line_number  = (i < 2) ? line_old_o : line_mid_o;
            cand[i].token_length = (32'(e_len[i]) > 32'd255) ? 8'hFF : 8'(32'(e_len[i]));
            cand[i].run_last     = 1'b0;
        end
    end

    // Pack the valid candidates in order; one byte never yields more than three
    always_comb begin
        o_res = '0;
        cnt   = '0;
        for (int i = 0; i < CAND; i++) begin
            if (e_v[i] && cnt < 2'(RES_MAX)) begin
                o_res[cnt] = cand[i];
                cnt = cnt + 2'd1;
            end
        end
        if (cnt != 2'd0) begin
            o_res[cnt - 2'd1].run_last = 1'b1;
        end
        o_res_cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_line <= LINE_BITS'(1);
            r_len  <= '0;
            r_win  <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_len  <= n_len;
            r_win  <= n_win;
        end
    end

endmodule

/* dv/c_subset_token_scanner_check.sv */
`timescale 1ns / 100ps
// Token predictor and comparator for the C-subset token scanner channels.
module c_subset_token_scanner_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cst_char_if         i_char,
    cst_token_if        i_token,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output logic [39:0] o_kinds_seen
);
    import cst_pkg::*;

    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_VT  = 8'd11;
    localparam logic [7:0] CH_FF  = 8'd12;
    localparam logic [7:0] CH_CR  = 8'd13;

    t_mode              scan_st;
    logic [LINE_W-1:0]  line_no;
    logic [LEN_W-1:0]   tok_len;
    logic [63:0]        kw_win;
    t_result            expected_toks[$];
    int                 fail_cnt = 0;
    int                 checked_cnt = 0;
    logic [39:0]        kinds_seen = '0;

    function automatic void clear_state();
        scan_st = M_START;
        line_no = 1;
        tok_len = '0;
        kw_win  = '0;
    endfunction

    function automatic bit letter_or_us(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void add_token(input logic [KIND_W-1:0] kind,
                                      input logic [LEN_W-1:0] len);
        t_result r;
        r.token_kind   = kind;
        r.line_number  = line_no;
        r.token_length = len;
        r.run_last     = 1'b0;
        expected_toks.insert(expected_toks.size(), r);
    endfunction

    function automatic void bump_line();
        if (line_no != '1) line_no++;
    endfunction

    // Keep the first eight bytes for the keyword compare; length saturates.
    function automatic void grow_token(input logic [7:0] c);
        if (tok_len < 8) kw_win = {kw_win[55:0], c};
        if (tok_len != '1) tok_len++;
    endfunction

    function automatic logic [KIND_W-1:0] word_kind();
        if (tok_len > 8) return K_IDENT;
        case (kw_win)
            "const":    return K_CONST;
            "main":     return K_MAIN;
            "int":      return K_INTKW;
            "break":    return K_BREAK;
            "continue": return K_CONT;
            "if":       return K_IF;
            "else":     return K_ELSE;
            "while":    return K_WHILE;
            "getint":   return K_GETINT;
            "printf":   return K_PRINTF;
            "return":   return K_RETURN;
            "void":     return K_VOID;
            default:    return K_IDENT;
        endcase
    endfunction

    function automatic void start_token(input logic [7:0] c);
        scan_st = M_START;
        tok_len = 1;
        case (c)
            CH_NL: begin
                bump_line();
                tok_len = 0;
            end
            CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: tok_len = 0;
            CH_QUOTE: scan_st = M_STR;
            CH_BANG:  scan_st = M_BANG;
            CH_AMP:   scan_st = M_AMP;
            CH_PIPE:  scan_st = M_PIPE;
            CH_LT:    scan_st = M_LT;
            CH_GT:    scan_st = M_GT;
            CH_EQ:    scan_st = M_EQ;
            CH_SLASH: scan_st = M_SLASH;
            "+":      add_token(K_PLUS, 1);
            "-":      add_token(K_MINUS, 1);
            CH_STAR:  add_token(K_MULT, 1);
            "%":      add_token(K_MOD, 1);
            ";":      add_token(K_SEMI, 1);
            ",":      add_token(K_COMMA, 1);
            "(":      add_token(K_LPAR, 1);
            ")":      add_token(K_RPAR, 1);
            "[":      add_token(K_LBRK, 1);
            "]":      add_token(K_RBRK, 1);
            "{":      add_token(K_LBRC, 1);
            "}":      add_token(K_RBRC, 1);
            default: begin
                if (letter_or_us(c)) begin
                    scan_st = M_IDENT;
                    tok_len = 0;
                    kw_win  = '0;
                    grow_token(c);
                end else if (decimal(c)) begin
                    scan_st = M_NUM;
                end else begin
                    scan_st = M_ERR;
                    add_token(K_ERR, 0);
                end
            end
        endcase
    endfunction

    // Close a one-or-two byte operator; return 1 when the byte is consumed.
    function automatic bit finish_pair(input logic [7:0] c, input logic [7:0] want,
                                       input logic [KIND_W-1:0] two,
                                       input logic [KIND_W-1:0] one);
        scan_st = M_START;
        if (c == want) begin
            add_token(two, 2);
            return 1'b1;
        end
        if (one == K_ERR) begin
            scan_st = M_ERR;
            add_token(K_ERR, 0);
            return 1'b1;
        end
        add_token(one, 1);
        return 1'b0;
    endfunction

    function automatic void scan_byte(input logic [7:0] c, input logic last);
        bit used;
        int base;
        used = 1'b0;
        base = expected_toks.size();
        case (scan_st)
            M_IDENT: begin
                if (letter_or_us(c) || decimal(c)) begin
                    grow_token(c);
                    used = 1'b1;
                end else begin
                    add_token(word_kind(), tok_len);
                    scan_st = M_START;
                end
            end
            M_NUM: begin
                if (decimal(c)) begin
                    grow_token(c);
                    used = 1'b1;
                end else begin
                    add_token(K_INT, tok_len);
                    scan_st = M_START;
                end
            end
            M_STR: begin
                used = 1'b1;
                if (c == CH_QUOTE) begin
                    grow_token(c);
                    add_token(K_STR, tok_len);
                    scan_st = M_START;
                end else if (c >= 8'd32 && c <= 8'd126) begin
                    grow_token(c);
                end else begin
                    add_token(K_ERR, 0);
                    scan_st = M_ERR;
                end
            end
            M_BANG: used = finish_pair(c, CH_EQ, K_NEQ, K_NOT);
            M_LT:   used = finish_pair(c, CH_EQ, K_LEQ, K_LSS);
            M_GT:   used = finish_pair(c, CH_EQ, K_GEQ, K_GRE);
            M_EQ:   used = finish_pair(c, CH_EQ, K_EQL, K_ASSIGN);
            M_AMP:  used = finish_pair(c, CH_AMP, K_AND, K_ERR);
            M_PIPE: used = finish_pair(c, CH_PIPE, K_OR, K_ERR);
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    scan_st = M_LCOM;
                    used = 1'b1;
                end else if (c == CH_STAR) begin
                    scan_st = M_BCOM;
                    used = 1'b1;
                end else begin
                    add_token(K_DIV, 1);
                    scan_st = M_START;
                end
            end
            M_LCOM: begin
                used = 1'b1;
                if (c == CH_NL) begin
                    bump_line();
                    scan_st = M_START;
                end
            end
            M_BCOM, M_BSTAR: begin
                used = 1'b1;
                if (c == CH_NL) begin
                    bump_line();
                    scan_st = M_BCOM;
                end else if (c == CH_STAR) begin
                    scan_st = M_BSTAR;
                end else if (c == CH_SLASH && scan_st == M_BSTAR) begin
                    scan_st = M_START;
                end else begin
                    scan_st = M_BCOM;
                end
            end
            M_ERR: used = 1'b1;
            default: scan_st = M_START;
        endcase
        if (!used) start_token(c);

        // Flush whatever is open at the end of the text, then mark the end.
        if (last) begin
            case (scan_st)
                M_IDENT: add_token(word_kind(), tok_len);
                M_NUM:   add_token(K_INT, tok_len);
                M_BANG:  add_token(K_NOT, 1);
                M_LT:    add_token(K_LSS, 1);
                M_GT:    add_token(K_GRE, 1);
                M_EQ:    add_token(K_ASSIGN, 1);
                M_SLASH: add_token(K_DIV, 1);
                M_STR, M_AMP, M_PIPE, M_BCOM, M_BSTAR: add_token(K_ERR, 0);
                default: ;
            endcase
            add_token(K_END, 0);
            clear_state();
        end
        if (expected_toks.size() > base)
            expected_toks[expected_toks.size() - 1].run_last = 1'b1;
    endfunction

    function automatic void check_token();
        t_result got;
        t_result want;
        got.token_kind   = i_token.token_kind;
        got.line_number  = i_token.line_number;
        got.token_length = i_token.token_length;
        got.run_last     = i_token.run_last;
        checked_cnt++;
        if (got.token_kind < 40) kinds_seen[got.token_kind] = 1'b1;
        if (expected_toks.size() == 0) begin
            fail_cnt++;
            $display("%0t: unexpected word: kind %0d line %0d length %0d last %0b",
                     $time, got.token_kind, got.line_number, got.token_length, got.run_last);
            return;
        end
        want = expected_toks.pop_front();
        if (got.token_kind !== want.token_kind || got.line_number !== want.line_number ||
            got.token_length !== want.token_length || got.run_last !== want.run_last) begin
            fail_cnt++;
            $display("%0t: mismatch: expected kind %0d line %0d length %0d last %0b,",
                     $time, want.token_kind, want.line_number, want.token_length,
                     want.run_last,
                     " got kind %0d line %0d length %0d last %0b",
                     got.token_kind, got.line_number, got.token_length, got.run_last);
        end
    endfunction

    // Compare first: a word leaving now was caused by an earlier byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_toks.delete();
        end else begin
            if (i_token.valid && i_token.ready) check_token();
            if (i_char.valid && i_char.ready) scan_byte(i_char.char_code, i_char.last_char);
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_toks.size();
        o_checked    <= checked_cnt;
        o_kinds_seen <= kinds_seen;
    end

endmodule

/* dv/c_subset_token_scanner_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the C-subset token scanner: source texts, stall patterns and verdict.
module c_subset_token_scanner_top_tb;
    import cst_pkg::*;

    localparam int         HOLD_CYCLES  = 80;   // long receiver hold-off
    localparam int         PHASE_BYTES  = 40;   // minimum random bytes per idling phase
    localparam logic [7:0] CH_TICK      = 8'd39;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          idle_pct;
    int          stall_pct;
    logic        holding;
    event        holdoff_go;
    int          fail_count;
    int          pending;
    int          checked;
    logic [39:0] kinds_seen;
    int          bytes_sent;
    int          texts_sent;
    logic [7:0]  src_q[$];

    cst_char_if  char_ch();
    cst_token_if token_ch();

    c_subset_token_scanner_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_token (token_ch)
    );

    c_subset_token_scanner_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (char_ch),
        .i_token      (token_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_kinds_seen (kinds_seen)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stall at the phase rate, or hold off completely during a squeeze.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            token_ch.ready <= 1'b0;
        end else begin
            token_ch.ready <= !holding && ($urandom_range(99) >= stall_pct);
        end
    end

    // Count the hold-off here so the sender keeps pushing bytes meanwhile.
    initial begin
        holding = 1'b0;
        forever begin
            @(holdoff_go);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    // Offer one byte, idling first at the phase rate; return once it is taken.
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            char_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.last_char <= last;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send the buffered text, flagging its final byte, and clear the buffer.
    task automatic send_text();
        for (int k = 0; k < src_q.size(); k++) begin
            send_byte(src_q[k], k == src_q.size() - 1);
        end
        src_q.delete();
        texts_sent++;
    endtask

    // Append one byte to the text being built.
    function automatic void put_byte(input logic [7:0] c);
        src_q.insert(src_q.size(), c);
    endfunction

    function automatic void put_str(input string s);
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
    endfunction

    function automatic string keyword(input int k);
        case (k)
            0:       return "const";
            1:       return "main";
            2:       return "int";
            3:       return "break";
            4:       return "continue";
            5:       return "if";
            6:       return "else";
            7:       return "while";
            8:       return "getint";
            9:       return "printf";
            10:      return "return";
            default: return "void";
        endcase
    endfunction

    // Letter, underscore, or (when allowed) digit.
    function automatic logic [7:0] word_char(input bit digits_ok);
        int r;
        r = $urandom_range(digits_ok ? 62 : 52);
        if (r < 26) return 8'(97 + r);
        if (r < 52) return 8'(65 + r - 26);
        if (r == 52) return 8'd95;
        return 8'(48 + r - 53);
    endfunction

    function automatic logic [7:0] printable();
        logic [7:0] c;
        c = 8'($urandom_range(126, 32));
        if (c == CH_QUOTE) c = CH_SPACE;
        return c;
    endfunction

    // Keywords, keywords with a tail (never a keyword past eight), plain names.
    function automatic void put_word();
        int n;
        if ($urandom_range(2) == 0) begin
            put_str(keyword($urandom_range(11)));
            if ($urandom_range(1)) put_byte(word_char(1'b1));
        end else begin
            n = $urandom_range(11, 1);
            put_byte(word_char(1'b0));
            for (int k = 1; k < n; k++) put_byte(word_char(1'b1));
        end
    endfunction

    // Append one lexical fragment: mostly well formed, sometimes broken or junk.
    function automatic void add_fragment(input bit noisy);
        string ops1;
        string ops2;
        string spaces;
        int    n;
        int    p;
        ops1   = "+-*/%;,()[]{}!<>=";
        ops2   = "!=&&||<=>===";
        spaces = "\040\011\012\013\014\015";
        if (noisy) begin
            case ($urandom_range(4))
                0: put_byte(8'($urandom_range(255)));
                1: begin
                    put_byte($urandom_range(1) ? CH_AMP : CH_PIPE);
                    put_byte(8'($urandom_range(255)));
                end
                2: put_byte(CH_TICK);
                3: begin
                    put_byte(CH_QUOTE);
                    put_str("open");
                end
                default: put_str("/*");
            endcase
        end else begin
            case ($urandom_range(8))
                0: put_word();
                1: begin
                    n = $urandom_range(5, 1);
                    repeat (n) put_byte(8'(48 + $urandom_range(9)));
                end
                2: begin
                    n = $urandom_range(6);
                    put_byte(CH_QUOTE);
                    repeat (n) put_byte(printable());
                    put_byte(CH_QUOTE);
                end
                3: put_byte(ops1[$urandom_range(ops1.len() - 1)]);
                4: begin
                    p = $urandom_range(5);
                    put_byte(ops2[2 * p]);
                    put_byte(ops2[2 * p + 1]);
                end
                5: begin
                    n = $urandom_range(6);
                    put_str("//");
                    repeat (n) put_byte(printable());
                    put_byte(CH_NL);
                end
                6: begin
                    n = $urandom_range(6);
                    put_str("/*");
                    repeat (n) begin
                        case ($urandom_range(3))
                            0:       put_byte(CH_NL);
                            1:       put_byte(CH_STAR);
                            default: put_byte(printable());
                        endcase
                    end
                    put_str("*/");
                end
                7: put_byte(spaces[$urandom_range(spaces.len() - 1)]);
                default: put_str(keyword($urandom_range(11)));
            endcase
        end
    endfunction

    function automatic void build_text();
        int frags;
        frags = $urandom_range(8, 2);
        for (int k = 0; k < frags; k++) begin
            add_fragment($urandom_range(99) < 12);
            if ($urandom_range(1)) put_byte(CH_SPACE);
        end
    endfunction

    // One idling mix of random texts; optionally squeeze the receiver at its start.
    task automatic run_phase(input int sender_idle, input int receiver_stall,
                             input bit squeeze);
        int start;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        start     = bytes_sent;
        if (squeeze) -> holdoff_go;
        while (bytes_sent - start < PHASE_BYTES) begin
            build_text();
            send_text();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        char_ch.last_char = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        bytes_sent        = 0;
        texts_sent        = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed texts: broken operators, junk bytes, open strings and comments.
        put_str("&x");                  // lone ampersand, next byte dropped
        send_text();
        put_str("|");                   // bar at the last byte
        send_text();
        put_byte(CH_TICK);              // character literal is an error
        send_text();
        put_byte(8'hFF);                // unknown byte, then drop to the end
        put_byte(8'h00);
        send_text();
        put_byte(CH_QUOTE);             // control byte inside a string
        put_byte(8'd9);
        send_text();
        put_str("\"ab");                // string open at the last byte
        send_text();
        put_str("/*");                  // block comment open at the last byte
        send_text();
        put_str("//a");                 // line comment closes quietly
        send_text();
        put_str("\011\013\014\015\012;"); // whitespace but space, one newline, then ;
        send_text();
        put_str("x<");                  // three words from one byte
        send_text();

        // Random texts under each idling mix; the first squeezes the receiver.
        run_phase(0, 0, 1'b1);
        run_phase(60, 0, 1'b0);
        run_phase(0, 60, 1'b0);
        run_phase(38, 38, 1'b0);
        char_ch.valid <= 1'b0;

        // Drain: pending is registered, so step the clock before trusting it.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes in %0d texts; %0d words checked, %0d of 40 token kinds seen.",
                 bytes_sent, texts_sent, checked, $countones(kinds_seen));
        $display("Mixes: no idling, sender gaps, receiver stalls, both; one long hold-off.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
